/* src/password_door_lock_controller_unit_macros.svh */
// Assertion macros shared by the door lock controller modules
`ifndef PASSWORD_DOOR_LOCK_CONTROLLER_UNIT_MACROS_SVH
`define PASSWORD_DOOR_LOCK_CONTROLLER_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define PDLC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PDLC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define PDLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pdlc_pkg.sv */
// Types and constants of the door lock controller
package pdlc_pkg;

    localparam int PASS_W     = 40;
    localparam int PASS_BYTES = 5;
    localparam int TICK_W     = 5;
    localparam int ATT_W      = 2;
    localparam int CFG_DATA_W = 5;
    localparam int QDEPTH     = 4;

    localparam logic [1:0] FUNC_PAIR = 2'd0;
    localparam logic [1:0] FUNC_REQ  = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    localparam logic [7:0] OP_OPEN  = 8'h2B;
    localparam logic [7:0] OP_LEAVE = 8'h2D;

    localparam logic [1:0] MOTOR_OFF = 2'd0;
    localparam logic [1:0] MOTOR_CW  = 2'd1;
    localparam logic [1:0] MOTOR_ACW = 2'd2;

    localparam logic [1:0] CFG_OPEN_TICKS  = 2'd0;
    localparam logic [1:0] CFG_PAUSE_TICKS = 2'd1;
    localparam logic [1:0] CFG_ALARM_TICKS = 2'd2;
    localparam logic [1:0] CFG_MAX_ATT     = 2'd3;

    localparam logic [TICK_W-1:0] RST_OPEN_TICKS  = 5'd5;
    localparam logic [TICK_W-1:0] RST_PAUSE_TICKS = 5'd1;
    localparam logic [TICK_W-1:0] RST_ALARM_TICKS = 5'd20;
    localparam logic [ATT_W-1:0]  RST_MAX_ATT     = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_MENU  = 3'd1,
        PH_CW    = 3'd2,
        PH_PAUSE = 3'd3,
        PH_ACW   = 3'd4,
        PH_ALARM = 3'd5
    } t_phase;

    typedef struct packed {
        logic [1:0]        func;
        logic [PASS_W-1:0] pass_first;
        logic [PASS_W-1:0] pass_second;
        logic [7:0]        operation;
    } t_in_item;

    typedef struct packed {
        logic       has_reply;
        logic       reply;
        logic [1:0] motor_drive;
        logic       alarm_on;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

    typedef struct packed {
        logic [TICK_W-1:0] open_ticks;
        logic [TICK_W-1:0] pause_ticks;
        logic [TICK_W-1:0] alarm_ticks;
        logic [ATT_W-1:0]  max_attempts;
    } t_cfg;

endpackage

/* src/pdlc_in_if.sv */
// Input channel: password pairs, unlock requests and ticks
interface pdlc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [39:0] pass_first;
    logic [39:0] pass_second;
    logic [7:0]  operation;

    modport source (output valid, output func, output pass_first, output pass_second,
                    output operation, input ready);
    modport sink   (input valid, input func, input pass_first, input pass_second,
                    input operation, output ready);
endinterface

/* src/pdlc_out_if.sv */
// Result channel: replies, motor and alarm status
interface pdlc_out_if;
    logic       valid;
    logic       ready;
    logic       has_reply;
    logic       reply;
    logic [1:0] motor_drive;
    logic       alarm_on;
    logic       last;

    modport source (output valid, output has_reply, output reply, output motor_drive,
                    output alarm_on, output last, input ready);
    modport sink   (input valid, input has_reply, input reply, input motor_drive,
                    input alarm_on, input last, output ready);
endinterface

/* src/pdlc_in_stage.sv */
// Input register stage of the door lock controller
module pdlc_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pdlc_in_if.sink            i_cmd,
    input  logic               i_take,
    output logic               o_valid,
    output pdlc_pkg::t_in_item o_item
);
    logic               r_valid;
    pdlc_pkg::t_in_item r_item;
    logic               w_acc;

    assign i_cmd.ready = !r_valid || i_take;
    assign w_acc       = i_cmd.valid && i_cmd.ready;
    assign o_valid     = r_valid;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_acc) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item.func        <= i_cmd.func;
            r_item.pass_first  <= i_cmd.pass_first;
            r_item.pass_second <= i_cmd.pass_second;
            r_item.operation   <= i_cmd.operation;
        end
    end
endmodule

/* src/pdlc_core.sv */
// Lock state machine: password check, attempt count and tick timing
`include "password_door_lock_controller_unit_macros.svh"
module pdlc_core #(
    parameter int PASS_DIGITS = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    input  pdlc_pkg::t_in_item i_item,
    input  pdlc_pkg::t_cfg     i_cfg,
    input  logic               i_room,
    output logic               o_take,
    output pdlc_pkg::t_push    o_push
);
    localparam int CMP_BITS = (PASS_DIGITS >= pdlc_pkg::PASS_BYTES) ?
                              pdlc_pkg::PASS_W : 8 * PASS_DIGITS;

    pdlc_pkg::t_phase             r_phase, n_phase;
    logic [CMP_BITS-1:0]          r_saved, n_saved;
    logic [pdlc_pkg::ATT_W-1:0]   r_failed, n_failed;
    logic [pdlc_pkg::TICK_W-1:0]  r_tick, n_tick;

    logic                         w_fire;
    logic [CMP_BITS-1:0]          w_p1;
    logic [CMP_BITS-1:0]          w_p2;
    logic [pdlc_pkg::ATT_W-1:0]   w_fail1;
    logic [pdlc_pkg::TICK_W-1:0]  w_tick1;
    logic [pdlc_pkg::TICK_W-1:0]  w_dur;
    pdlc_pkg::t_push              w_push;

    function automatic logic [1:0] motor_of(input pdlc_pkg::t_phase ph);
        logic [1:0] m;
        unique case (ph)
            pdlc_pkg::PH_CW:  m = pdlc_pkg::MOTOR_CW;
            pdlc_pkg::PH_ACW: m = pdlc_pkg::MOTOR_ACW;
            default:          m = pdlc_pkg::MOTOR_OFF;
        endcase
        return m;
    endfunction

    assign w_fire  = i_item_valid && i_room;
    assign o_take  = w_fire;
    assign w_p1    = i_item.pass_first[CMP_BITS-1:0];
    assign w_p2    = i_item.pass_second[CMP_BITS-1:0];
    assign w_fail1 = r_failed + 2'd1;
    assign w_tick1 = r_tick + 5'd1;

    always_comb begin
        unique case (r_phase)
            pdlc_pkg::PH_PAUSE: w_dur = i_cfg.pause_ticks;
            pdlc_pkg::PH_ALARM: w_dur = i_cfg.alarm_ticks;
            default:            w_dur = i_cfg.open_ticks;
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_saved  = r_saved;
        n_failed = r_failed;
        n_tick   = r_tick;
        w_push   = '0;
        w_push.n = 2'd1;
        w_push.r0.last = 1'b1;
        priority if (i_item.func == pdlc_pkg::FUNC_PAIR && r_phase == pdlc_pkg::PH_IDLE) begin
            if (w_p1 == w_p2) begin
                n_saved  = w_p1;
                n_failed = '0;
                n_phase  = pdlc_pkg::PH_MENU;
            end
            w_push.r0.has_reply = 1'b1;
            w_push.r0.reply     = (w_p1 != w_p2);
        end else if (i_item.func == pdlc_pkg::FUNC_REQ && r_phase == pdlc_pkg::PH_MENU) begin
            w_push.r0.has_reply = 1'b1;
            if (w_p1 == r_saved) begin
                if (i_item.operation == pdlc_pkg::OP_OPEN) begin
                    n_phase = pdlc_pkg::PH_CW;
                    n_tick  = '0;
                end else if (i_item.operation == pdlc_pkg::OP_LEAVE) begin
                    n_phase = pdlc_pkg::PH_IDLE;
                end
                w_push.r0.motor_drive = motor_of(n_phase);
            end else if (w_fail1 >= i_cfg.max_attempts || w_fail1 == '0) begin
                n_failed = '0;
                n_tick   = '0;
                n_phase  = pdlc_pkg::PH_ALARM;
                w_push.n = 2'd2;
                w_push.r0.reply = 1'b1;
                w_push.r0.last  = 1'b0;
                w_push.r1.has_reply = 1'b1;
                w_push.r1.reply     = 1'b1;
                w_push.r1.alarm_on  = 1'b1;
                w_push.r1.last      = 1'b1;
            end else begin
                n_failed = w_fail1;
                w_push.r0.reply = 1'b1;
            end
        end else begin
            if (i_item.func == pdlc_pkg::FUNC_TICK && r_phase != pdlc_pkg::PH_IDLE &&
                r_phase != pdlc_pkg::PH_MENU) begin
                if (w_tick1 >= w_dur) begin
                    n_tick = '0;
                    unique case (r_phase)
                        pdlc_pkg::PH_CW:    n_phase = pdlc_pkg::PH_PAUSE;
                        pdlc_pkg::PH_PAUSE: n_phase = pdlc_pkg::PH_ACW;
                        default:            n_phase = pdlc_pkg::PH_IDLE;
                    endcase
                end else begin
                    n_tick = w_tick1;
                end
            end
            w_push.r0.motor_drive = motor_of(n_phase);
            w_push.r0.alarm_on    = (n_phase == pdlc_pkg::PH_ALARM);
        end
    end

    always_comb begin
        o_push = w_push;
        if (!w_fire) begin
            o_push.n = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= pdlc_pkg::PH_IDLE;
            r_failed <= '0;
            r_tick   <= '0;
        end else if (w_fire) begin
            r_phase  <= n_phase;
            r_failed <= n_failed;
            r_tick   <= n_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_saved <= n_saved;
        end
    end

    `PDLC_ASSERT_IMP(a_two_results_lockout, o_push.n == 2'd2, !o_push.r0.last && o_push.r1.alarm_on && o_push.r1.last, "two results must be a lockout pair")
    `PDLC_ASSERT_NEXT(a_alarm_entry, r_phase != pdlc_pkg::PH_ALARM && o_push.n != 2'd2, r_phase != pdlc_pkg::PH_ALARM, "alarm entered without lockout")
    `PDLC_ASSERT_IMP(a_tick_clear, r_phase == pdlc_pkg::PH_IDLE || r_phase == pdlc_pkg::PH_MENU, r_tick == '0, "tick count left over outside timed phases")
endmodule

/* src/pdlc_out_queue.sv */
// Result queue that decouples the state machine from the result channel
`include "password_door_lock_controller_unit_macros.svh"
module pdlc_out_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pdlc_pkg::t_push i_push,
    output logic            o_room,
    pdlc_out_if.source      o_res
);
    localparam int AW = $clog2(pdlc_pkg::QDEPTH);

    pdlc_pkg::t_result r_mem [pdlc_pkg::QDEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [AW:0]       r_cnt;
    logic              w_pop;
    pdlc_pkg::t_result w_head;

    assign w_pop  = o_res.valid && o_res.ready;
    assign o_room = r_cnt <= (AW + 1)'(pdlc_pkg::QDEPTH - 2);
    assign w_head = r_mem[r_rd];

    assign o_res.valid       = r_cnt != '0;
    assign o_res.has_reply   = w_head.has_reply;
    assign o_res.reply       = w_head.reply;
    assign o_res.motor_drive = w_head.motor_drive;
    assign o_res.alarm_on    = w_head.alarm_on;
    assign o_res.last        = w_head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + AW'(i_push.n);
            r_rd  <= r_rd + AW'(w_pop);
            r_cnt <= r_cnt + (AW + 1)'(i_push.n) - (AW + 1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wr + AW'(1)] <= i_push.r1;
        end
    end

    `PDLC_ASSERT_ALWAYS(a_cnt_bound, r_cnt <= (AW + 1)'(pdlc_pkg::QDEPTH), "result queue overflow")
    `PDLC_ASSERT_IMP(a_push_room, i_push.n != 2'd0, r_cnt <= (AW + 1)'(pdlc_pkg::QDEPTH - 2), "push without room")
    `PDLC_ASSERT_NEXT(a_last_follow, w_pop && !o_res.last, o_res.valid, "first result of a pair left alone")
endmodule

/* src/password_door_lock_controller_unit.sv */
// Door lock controller top level: configuration registers and datapath
//
//   channel  | dir | handshake     | word
//   ---------+-----+---------------+------------------------------------------
//   i_cmd    | in  | valid / ready | func, pass_first, pass_second, operation
//   o_res    | out | valid / ready | has_reply, reply, motor_drive, alarm_on, last
//   i_cfg_*  | in  | write enable  | register index, register data
//
// One word per cycle while the result queue has room: input register, one pass through
// the state machine, result queue. A word is registered, then its results are queued.
// A lockout request leaves two results; the four-entry queue absorbs them.
// o_res stalls back up into i_cmd only once the queue holds more than two results.
// Reset is synchronous and clears the phase, attempt and tick counts, and the queue.
module password_door_lock_controller_unit #(
    parameter int PASS_DIGITS = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pdlc_in_if.sink                           i_cmd,
    pdlc_out_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [pdlc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    pdlc_pkg::t_cfg     r_cfg;
    logic               w_item_valid;
    pdlc_pkg::t_in_item w_item;
    logic               w_take;
    logic               w_room;
    pdlc_pkg::t_push    w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_ticks   <= pdlc_pkg::RST_OPEN_TICKS;
            r_cfg.pause_ticks  <= pdlc_pkg::RST_PAUSE_TICKS;
            r_cfg.alarm_ticks  <= pdlc_pkg::RST_ALARM_TICKS;
            r_cfg.max_attempts <= pdlc_pkg::RST_MAX_ATT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pdlc_pkg::CFG_OPEN_TICKS:  r_cfg.open_ticks   <= i_cfg_data;
                pdlc_pkg::CFG_PAUSE_TICKS: r_cfg.pause_ticks  <= i_cfg_data;
                pdlc_pkg::CFG_ALARM_TICKS: r_cfg.alarm_ticks  <= i_cfg_data;
                pdlc_pkg::CFG_MAX_ATT:     r_cfg.max_attempts <= i_cfg_data[pdlc_pkg::ATT_W-1:0];
            endcase
        end
    end

    pdlc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_take  (w_take),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    pdlc_core #(
        .PASS_DIGITS (PASS_DIGITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .i_cfg        (r_cfg),
        .i_room       (w_room),
        .o_take       (w_take),
        .o_push       (w_push)
    );

    pdlc_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_res   (o_res)
    );
endmodule
